// ===== rtl/core/swoir_pkg.sv =====
// Shared types and constants for the offset stack block.
// Holds the channel word types, opcode and status codes and the cell command.
// No dependencies.
`timescale 1ns / 1ps

package swoir_pkg;

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int OFFSET_W = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Number of cells folded into one register of the read tree.
   localparam int GROUP_SIZE = 8;

   localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OFFSET = 2'd3;

   // How the cells move on a write.
   localparam logic [1:0] SHIFT_PUSH   = 2'd0;
   localparam logic [1:0] SHIFT_POP    = 2'd1;
   localparam logic [1:0] SHIFT_INSERT = 2'd2;
   localparam logic [1:0] SHIFT_REMOVE = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  value;
      logic [OFFSET_W-1:0] offset;
   } req_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  data_out;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } rsp_word_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic                write;
      logic [1:0]          kind;
      logic                read;
      logic                read_at_offset;
      logic [OFFSET_W-1:0] offset;
   } cell_cmd_type;

endpackage

// ===== rtl/core/stack_with_offset_insert_remove_unit.sv =====
// Top level of the offset stack: control, the cell chain and the read tree.
// Depends on swoir_pkg, swoir_cell and swoir_tap_tree.
//
// A fixed-depth stack held in a chain of cells, cell 0 being the top.
// Each request word carries an opcode (push, pop, peek, insert below the
// top offset+1 entries, remove at depth offset, clear), a value and an
// offset. Every request word returns exactly one response word with the
// read data, a status code and the entry count after the operation.
// Push, pop, insert and remove move all cells at once in the cycle the
// request is accepted, so a new request can be taken every cycle while the receiver does not stall.
// The selected cell word is folded through a registered OR tree into the
// middle stage, and the response word then passes into the output register.
// When the receiver stalls, the response holds in that register and one
// more request can still be taken into the middle stage; further requests
// are stalled until the output drains.
// Reset empties the stack and drops any words in flight; entry contents
// are not cleared, only the count, since entries beyond it are never read.
`timescale 1ns / 1ps

module stack_with_offset_insert_remove_unit #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  swoir_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output swoir_pkg::rsp_word_type rsp_word
);

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CMP_W  = (FILL_W > swoir_pkg::OFFSET_W) ? FILL_W : swoir_pkg::OFFSET_W;

   logic [FILL_W-1:0]            fill_ff;
   logic [FILL_W-1:0]            fill_in;
   logic [FILL_W-1:0]            fill_next;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [swoir_pkg::STATUS_W-1:0] s1_status_ff;
   logic [swoir_pkg::COUNT_W-1:0]  s1_count_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   swoir_pkg::rsp_word_type      rsp_word_ff;
   swoir_pkg::rsp_word_type      rsp_word_in;

   logic                         req_acc;
   logic                         s1_adv;
   logic                         is_full;
   logic                         is_empty;
   logic                         off_bad;
   logic [swoir_pkg::STATUS_W-1:0] status;
   swoir_pkg::cell_cmd_type      cmd;
   swoir_pkg::cell_cmd_type      cmd_gated;
   logic [DATA_WIDTH-1:0]        load_val;
   logic [DATA_WIDTH-1:0]        cell_data [DEPTH];
   logic [DATA_WIDTH-1:0]        cell_tap  [DEPTH];
   logic [DATA_WIDTH-1:0]        read_word;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   assign is_full  = fill_ff == FILL_W'(DEPTH);
   assign is_empty = fill_ff == '0;
   assign off_bad  = CMP_W'(req_word.offset) >= CMP_W'(fill_ff);
   assign load_val = DATA_WIDTH'(req_word.value);

   always_comb begin
      status             = swoir_pkg::ST_OK;
      fill_next          = fill_ff;
      cmd.write          = 1'b0;
      cmd.kind           = swoir_pkg::SHIFT_PUSH;
      cmd.read           = 1'b0;
      cmd.read_at_offset = 1'b0;
      cmd.offset         = req_word.offset;
      case (req_word.opcode)
         swoir_pkg::OP_PUSH: begin
            if (is_full) begin
               status = swoir_pkg::ST_FULL;
            end else begin
               cmd.write = 1'b1;
               fill_next = fill_ff + 1'b1;
            end
         end
         swoir_pkg::OP_POP: begin
            if (is_empty) begin
               status = swoir_pkg::ST_EMPTY;
            end else begin
               cmd.write = 1'b1;
               cmd.kind  = swoir_pkg::SHIFT_POP;
               cmd.read  = 1'b1;
               fill_next = fill_ff - 1'b1;
            end
         end
         swoir_pkg::OP_PEEK: begin
            if (is_empty) begin
               status = swoir_pkg::ST_EMPTY;
            end else begin
               cmd.read = 1'b1;
            end
         end
         swoir_pkg::OP_INSERT: begin
            // Full takes priority over a bad offset.
            if (is_full) begin
               status = swoir_pkg::ST_FULL;
            end else if (off_bad) begin
               status = swoir_pkg::ST_OFFSET;
            end else begin
               cmd.write = 1'b1;
               cmd.kind  = swoir_pkg::SHIFT_INSERT;
               fill_next = fill_ff + 1'b1;
            end
         end
         swoir_pkg::OP_REMOVE: begin
            if (is_empty) begin
               status = swoir_pkg::ST_EMPTY;
            end else if (off_bad) begin
               status = swoir_pkg::ST_OFFSET;
            end else begin
               cmd.write          = 1'b1;
               cmd.kind           = swoir_pkg::SHIFT_REMOVE;
               cmd.read           = 1'b1;
               cmd.read_at_offset = 1'b1;
               fill_next          = fill_ff - 1'b1;
            end
         end
         swoir_pkg::OP_CLEAR: begin
            fill_next = '0;
         end
         default: begin
            fill_next = fill_ff;
         end
      endcase
   end

   always_comb begin
      cmd_gated       = cmd;
      cmd_gated.write = cmd.write && req_acc;
      cmd_gated.read  = cmd.read && req_acc;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] shallow_data;
      logic [DATA_WIDTH-1:0] deep_data;

      if (i == 0) begin : g_top
         assign shallow_data = load_val;
      end else begin : g_mid_s
         assign shallow_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_bottom
         assign deep_data = '0;
      end else begin : g_mid_d
         assign deep_data = cell_data[i+1];
      end

      swoir_cell #(
         .INDEX      (i),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock        (clock),
         .cmd          (cmd_gated),
         .load_data    (load_val),
         .shallow_data (shallow_data),
         .deep_data    (deep_data),
         .data         (cell_data[i]),
         .tap          (cell_tap[i])
      );
   end

   swoir_tap_tree #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_tap_tree (
      .clock   (clock),
      .capture (req_acc),
      .taps    (cell_tap),
      .result  (read_word)
   );

   assign fill_in      = req_acc ? fill_next : fill_ff;
   assign s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_word_in          = rsp_word_ff;
      if (s1_adv) begin
         rsp_word_in.data_out = swoir_pkg::VALUE_W'(read_word);
         rsp_word_in.status   = s1_status_ff;
         rsp_word_in.count    = s1_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_status_ff <= status;
         s1_count_ff  <= swoir_pkg::COUNT_W'(fill_next);
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== rtl/core/swoir_cell.sv =====
// One entry of the stack chain; INDEX is its depth below the top.
// Depends on swoir_pkg for the cell command type and shift codes.
`timescale 1ns / 1ps

module swoir_cell #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  swoir_pkg::cell_cmd_type  cmd,
   input  logic [DATA_WIDTH-1:0]    load_data,
   input  logic [DATA_WIDTH-1:0]    shallow_data,
   input  logic [DATA_WIDTH-1:0]    deep_data,
   output logic [DATA_WIDTH-1:0]    data,
   output logic [DATA_WIDTH-1:0]    tap
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  below_off;
   logic                  at_off;
   logic                  at_insert;
   logic                  selected;

   assign below_off = INDEX < int'(cmd.offset);
   assign at_off    = INDEX == int'(cmd.offset);
   assign at_insert = INDEX == int'(cmd.offset) + 1;

   always_comb begin
      data_in = data_ff;
      if (cmd.write) begin
         case (cmd.kind)
            swoir_pkg::SHIFT_PUSH: begin
               data_in = (INDEX == 0) ? load_data : shallow_data;
            end
            swoir_pkg::SHIFT_POP: begin
               data_in = deep_data;
            end
            swoir_pkg::SHIFT_INSERT: begin
               // Entries at or above the offset stay; the new word lands just below them.
               if (below_off || at_off) begin
                  data_in = data_ff;
               end else if (at_insert) begin
                  data_in = load_data;
               end else begin
                  data_in = shallow_data;
               end
            end
            swoir_pkg::SHIFT_REMOVE: begin
               data_in = below_off ? data_ff : deep_data;
            end
            default: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign selected = cmd.read && (cmd.read_at_offset ? at_off : (INDEX == 0));
   assign tap      = selected ? data_ff : '0;
   assign data     = data_ff;

endmodule

// ===== rtl/core/swoir_tap_tree.sv =====
// Registered OR tree that collects the one selected cell word.
// Depends on swoir_pkg for the group size.
`timescale 1ns / 1ps

module swoir_tap_tree #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  capture,
   input  logic [DATA_WIDTH-1:0] taps [DEPTH],
   output logic [DATA_WIDTH-1:0] result
);

   localparam int GS   = swoir_pkg::GROUP_SIZE;
   localparam int NGRP = (DEPTH + GS - 1) / GS;

   logic [DATA_WIDTH-1:0] part   [NGRP][GS];
   logic [DATA_WIDTH-1:0] grp_in [NGRP];
   logic [DATA_WIDTH-1:0] grp_ff [NGRP];

   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      for (genvar k = 0; k < GS; k++) begin : g_leaf
         if (g * GS + k < DEPTH) begin : g_used
            assign part[g][k] = taps[g * GS + k];
         end else begin : g_pad
            assign part[g][k] = '0;
         end
      end

      always_comb begin
         grp_in[g] = '0;
         for (int k = 0; k < GS; k++) begin
            grp_in[g] = grp_in[g] | part[g][k];
         end
      end

      always_ff @(posedge clock) begin
         if (capture) begin
            grp_ff[g] <= grp_in[g];
         end
      end
   end

   // At most one cell drives a nonzero tap, so OR gives its word.
   always_comb begin
      result = '0;
      for (int g = 0; g < NGRP; g++) begin
         result = result | grp_ff[g];
      end
   end

endmodule
